// ===== rtl/core/msm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// msm_pkg
// Shared types, register codes, reset values and fixed-point constants of the
// multimode sample modulator, plus the cosine table builder.
// ============================================================================

package msm_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int COS_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W   = 10;
    localparam int CODE_W     = 8;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 32;
    localparam int DEPTH_W    = 16;
    localparam int COS_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_AM  = 2'd0,
        MODE_PM  = 2'd1,
        MODE_ASK = 2'd2,
        MODE_FSK = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE         = 2'd0,
        REG_CARRIER_STEP = 2'd1,
        REG_TONE_STEP    = 2'd2,
        REG_PHASE_DEPTH  = 2'd3
    } cfg_reg_t;

    localparam mode_t               MODE_RST         = MODE_FSK;
    localparam logic [STEP_W-1:0]   CARRIER_STEP_RST = 32'd429496730;
    localparam logic [STEP_W-1:0]   TONE_STEP_RST    = 32'd42949673;
    localparam logic [DEPTH_W-1:0]  PHASE_DEPTH_RST  = 16'd10430;

    // floor(255*x/1023) = (x * SCALE_MUL) >> SCALE_SHIFT for 10-bit x
    localparam logic [25:0] SCALE_MUL   = 26'd66912255;
    localparam int          SCALE_SHIFT = 28;

    // floor(n/255) = (n * DEPTH_RECIP) >> DEPTH_SHIFT for n below 2^24
    localparam logic [24:0] DEPTH_RECIP = 25'd16843010;
    localparam int          DEPTH_SHIFT = 32;

    // floor(n/65534) = (n * CODE_RECIP) >> CODE_SHIFT for n below 2^24
    localparam logic [24:0] CODE_RECIP = 25'd16777729;
    localparam int          CODE_SHIFT = 40;

    // 128 * 65534, bias of the keyed carrier
    localparam logic signed [24:0] KEY_BIAS = 25'sd8388352;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // sin(pi/2 * j / quarter) scaled to 32767, odd polynomial in Q30
    function automatic logic [COS_W-1:0] quarter_sine(input int unsigned j,
                                                     input int tb);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        s;
        logic signed [63:0] sum;
        x    = (64'(j) * HALF_PI_Q30) >> (tb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        s = 64'(sum);
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return COS_W'((s * 64'd32767 + (Q30_ONE >> 1)) >> 30);
    endfunction

    // cosine table entry k of a table with 2^tb entries, Q1.15
    function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned k,
                                                         input int tb);
        int unsigned        quarter;
        int unsigned        q;
        int unsigned        r;
        logic signed [COS_W-1:0] v;
        quarter = 32'd1 << (tb - 2);
        q       = k >> (tb - 2);
        r       = k & (quarter - 1);
        case (q)
            0:       v = $signed(quarter_sine(quarter - r, tb));
            1:       v = -$signed(quarter_sine(r, tb));
            2:       v = -$signed(quarter_sine(quarter - r, tb));
            default: v = $signed(quarter_sine(r, tb));
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/multimode_sample_modulator_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multimode_sample_modulator_unit
// Phase-accumulator modulator: 10-bit message sample in, 8-bit DAC code out,
// in AM, phase, ASK or FSK mode, carrier from a registered cosine ROM.
// ============================================================================
//
// Usage:
//   Input channel s_tvalid/s_tready/s_tdata carries one message sample per
//   item; output channel m_tvalid/m_tready/m_tdata carries one DAC code per
//   item, in input order. The cfg_wen/cfg_addr/cfg_wdata port writes mode,
//   carrier_step, tone_step and phase_depth (index 0..3); the user must write
//   only while no item is in flight, as the block itself does not enforce it.
//   Throughput is one item per clock while the output is not stalled. An
//   accepted input passes through seven register stages: sample scaling
//   multiply, deviation multiply, divide by 255, ROM address and registered
//   ROM read, carrier product, divide by 65534, output register. The single
//   ROM read port sets one item per clock.
//   Both phase accumulators advance by their steps on every accepted item;
//   each item uses the phases as they stood when it was accepted.
//   Reset clears the pipeline and both phases and loads the default register
//   values. When the receiver stalls, results stay in place and empty stages
//   keep filling; s_tready drops only once all seven stages hold an item.
//
module multimode_sample_modulator_unit #(
    parameter int PHASE_BITS     = msm_pkg::PHASE_BITS_DEF,
    parameter int COS_TABLE_BITS = msm_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [msm_pkg::IN_TDATA_W-1:0]      s_tdata,   // [9:0] adc_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msm_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [7:0] dac_code
    input  logic                                cfg_wen,
    input  logic [msm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [msm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int ROM_SIZE = 1 << COS_TABLE_BITS;
    localparam int NSTAGE   = 7;
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS - 2){1'b0}}};

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    msm_pkg::mode_t                   mode_reg;
    logic [msm_pkg::STEP_W-1:0]       carrier_step_reg;
    logic [msm_pkg::STEP_W-1:0]       tone_step_reg;
    logic [msm_pkg::DEPTH_W-1:0]      phase_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= msm_pkg::MODE_RST;
            carrier_step_reg <= msm_pkg::CARRIER_STEP_RST;
            tone_step_reg    <= msm_pkg::TONE_STEP_RST;
            phase_depth_reg  <= msm_pkg::PHASE_DEPTH_RST;
        end
        else if (cfg_wen)
        begin
            case (msm_pkg::cfg_reg_t'(cfg_addr))
                msm_pkg::REG_MODE:
                    mode_reg <= msm_pkg::mode_t'(cfg_wdata[msm_pkg::MODE_W-1:0]);
                msm_pkg::REG_CARRIER_STEP:
                    carrier_step_reg <= cfg_wdata[msm_pkg::STEP_W-1:0];
                msm_pkg::REG_TONE_STEP:
                    tone_step_reg <= cfg_wdata[msm_pkg::STEP_W-1:0];
                msm_pkg::REG_PHASE_DEPTH:
                    phase_depth_reg <= cfg_wdata[msm_pkg::DEPTH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------------
    logic [NSTAGE:1]   v_reg;
    logic [NSTAGE:1]   v_next;
    logic [NSTAGE+1:1] rdy;
    logic              in_acc;

    always_comb
    begin
        rdy[NSTAGE+1] = m_tready;
        for (int k = NSTAGE; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        v_next[1] = rdy[1] ? s_tvalid : v_reg[1];
        for (int k = 2; k <= NSTAGE; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = rdy[1];
    assign in_acc   = s_tvalid && rdy[1];

    // ------------------------------------------------------------------------
    // Phase accumulators
    // ------------------------------------------------------------------------
    logic [PHASE_BITS-1:0] carrier_phase_reg;
    logic [PHASE_BITS-1:0] tone_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg <= '0;
            tone_phase_reg    <= '0;
        end
        else if (in_acc)
        begin
            carrier_phase_reg <= carrier_phase_reg + PHASE_BITS'(carrier_step_reg);
            tone_phase_reg    <= tone_phase_reg + PHASE_BITS'(tone_step_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: scale sample to a byte
    // ------------------------------------------------------------------------
    logic [35:0]           scale_prod;
    logic [7:0]            b1_reg;
    logic [PHASE_BITS-1:0] cph1_reg;
    logic [PHASE_BITS-1:0] tph1_reg;

    assign scale_prod = 36'(s_tdata[msm_pkg::SAMPLE_W-1:0]) * 36'(msm_pkg::SCALE_MUL);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b1_reg   <= scale_prod[msm_pkg::SCALE_SHIFT +: 8];
            cph1_reg <= carrier_phase_reg;
            tph1_reg <= tone_phase_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: deviation magnitude times depth
    // ------------------------------------------------------------------------
    logic [8:0]            twice_b1;
    logic [7:0]            mag1;
    logic [23:0]           dev2_reg;
    logic                  neg2_reg;
    logic [7:0]            b2_reg;
    logic [PHASE_BITS-1:0] cph2_reg;
    logic [PHASE_BITS-1:0] tph2_reg;

    assign twice_b1 = {b1_reg, 1'b0};
    assign mag1     = b1_reg[7] ? 8'(twice_b1 - 9'd255) : 8'(9'd255 - twice_b1);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            dev2_reg <= 24'(mag1) * 24'(phase_depth_reg);
            neg2_reg <= !b1_reg[7];
            b2_reg   <= b1_reg;
            cph2_reg <= cph1_reg;
            tph2_reg <= tph1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: divide by 255, apply sign
    // ------------------------------------------------------------------------
    logic [48:0]             dev_quot;
    logic [15:0]             off_mag;
    logic signed [16:0]      off3_reg;
    logic [7:0]              b3_reg;
    logic [PHASE_BITS-1:0]   cph3_reg;
    logic [PHASE_BITS-1:0]   tph3_reg;

    assign dev_quot = 49'(dev2_reg) * 49'(msm_pkg::DEPTH_RECIP);
    assign off_mag  = dev_quot[msm_pkg::DEPTH_SHIFT +: 16];

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            off3_reg <= neg2_reg ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
            b3_reg   <= b2_reg;
            cph3_reg <= cph2_reg;
            tph3_reg <= tph2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: ROM address and registered ROM read
    // ------------------------------------------------------------------------
    logic signed [msm_pkg::COS_W-1:0] cos_rom [ROM_SIZE];

    for (genvar k = 0; k < ROM_SIZE; k++)
    begin : g_rom
        assign cos_rom[k] = msm_pkg::cos_entry(k, COS_TABLE_BITS);
    end

    logic [PHASE_BITS-1:0]            off_ext;
    logic [PHASE_BITS-1:0]            off_ph;
    logic                             hi3;
    logic [PHASE_BITS-1:0]            rom_phase;
    logic [COS_TABLE_BITS-1:0]        rom_idx;
    logic signed [msm_pkg::COS_W-1:0] c4_reg;
    logic [7:0]                       b4_reg;

    assign off_ext = PHASE_BITS'(off3_reg);
    assign off_ph  = off_ext << (PHASE_BITS - msm_pkg::DEPTH_W);
    assign hi3     = b3_reg > 8'd128;

    always_comb
    begin
        case (mode_reg)
            msm_pkg::MODE_PM:  rom_phase = cph3_reg + off_ph;
            msm_pkg::MODE_FSK: rom_phase = hi3 ? cph3_reg : tph3_reg - QUARTER;
            default:           rom_phase = cph3_reg;
        endcase
    end

    assign rom_idx = rom_phase[PHASE_BITS-1 -: COS_TABLE_BITS];

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            c4_reg <= cos_rom[rom_idx];
            b4_reg <= b3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: carrier product
    // ------------------------------------------------------------------------
    logic signed [9:0]  centred4;
    logic signed [9:0]  factor4;
    logic signed [24:0] prod5_reg;
    logic               hi5_reg;

    assign centred4 = $signed({1'b0, b4_reg, 1'b0}) - 10'sd255;
    assign factor4  = (mode_reg == msm_pkg::MODE_AM) ? centred4 : 10'sd255;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            prod5_reg <= 25'(factor4) * 25'(c4_reg);
            hi5_reg   <= b4_reg > 8'd128;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: divide by 65534
    // ------------------------------------------------------------------------
    logic               keyed5;
    logic signed [24:0] biased5;
    logic signed [24:0] abs5;
    logic [23:0]        num5;
    logic [48:0]        code_quot;
    logic [7:0]         q6_reg;
    logic               neg6_reg;
    logic               hi6_reg;

    assign keyed5    = (mode_reg == msm_pkg::MODE_ASK) || (mode_reg == msm_pkg::MODE_FSK);
    assign biased5   = prod5_reg + msm_pkg::KEY_BIAS;
    assign abs5      = prod5_reg[24] ? -prod5_reg : prod5_reg;
    assign num5      = keyed5 ? 24'(biased5) : 24'(abs5);
    assign code_quot = 49'(num5) * 49'(msm_pkg::CODE_RECIP);

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            q6_reg   <= code_quot[msm_pkg::CODE_SHIFT +: 8];
            neg6_reg <= prod5_reg[24];
            hi6_reg  <= hi5_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: code assembly, saturation, output register
    // ------------------------------------------------------------------------
    logic [8:0]                  res6;
    logic [msm_pkg::CODE_W-1:0]  code7_reg;

    always_comb
    begin
        case (mode_reg)
            msm_pkg::MODE_AM,
            msm_pkg::MODE_PM:  res6 = neg6_reg ? 9'd128 - 9'(q6_reg) : 9'd128 + 9'(q6_reg);
            msm_pkg::MODE_ASK: res6 = hi6_reg ? 9'(q6_reg) : 9'd127;
            default:           res6 = 9'(q6_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            code7_reg <= res6[8] ? 8'hFF : res6[7:0];
        end
    end

    assign m_tvalid = v_reg[NSTAGE];
    assign m_tdata  = msm_pkg::OUT_TDATA_W'(code7_reg);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_carrier_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> carrier_phase_reg == $past(carrier_phase_reg))
        else $error("carrier phase moved without an accepted item");

    a_tone_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> tone_phase_reg == $past(tone_phase_reg + PHASE_BITS'(tone_step_reg)))
        else $error("tone phase did not advance by its step");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

endmodule

// ===== test/multimode_sample_modulator_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multimode_sample_modulator_unit_tb
// Streams message samples through the modulator under a series of register
// settings (all four modes, step and depth extremes, random settings) and
// compares every DAC code against a cycle-free predictor of the carrier and
// tone phase accumulators, with random bursts on the input and stalls on the
// output.
// ============================================================================

module multimode_sample_modulator_unit_tb;

    localparam int IDX_SHIFT  = msm_pkg::PHASE_BITS_DEF - msm_pkg::COS_TABLE_BITS_DEF;
    localparam int TABLE_LEN  = 1 << msm_pkg::COS_TABLE_BITS_DEF;
    localparam int NUM_PHASES = 12;
    localparam int RANDOM_PER_PHASE = 150;

    class dac_scoreboard;
        int             cos_tab [TABLE_LEN];
        msm_pkg::mode_t mode;
        logic [31:0]    carrier_step;
        logic [31:0]    tone_step;
        logic [15:0]    phase_depth;
        logic [31:0]    carrier_phase;
        logic [31:0]    tone_phase;
        logic [7:0]     expected_codes [$];
        int             errors;
        int             samples;
        int             codes;

        function new();
            int unsigned k;
            int unsigned q;
            int unsigned r;
            int unsigned quarter;
            quarter = TABLE_LEN / 4;
            for (k = 0; k < TABLE_LEN; k++)
            begin
                q = k / quarter;
                r = k % quarter;
                case (q)
                    0:       cos_tab[k] = quarter_wave(quarter - r);
                    1:       cos_tab[k] = -quarter_wave(r);
                    2:       cos_tab[k] = -quarter_wave(quarter - r);
                    default: cos_tab[k] = quarter_wave(r);
                endcase
            end
            mode          = msm_pkg::MODE_RST;
            carrier_step  = msm_pkg::CARRIER_STEP_RST;
            tone_step     = msm_pkg::TONE_STEP_RST;
            phase_depth   = msm_pkg::PHASE_DEPTH_RST;
            carrier_phase = '0;
            tone_phase    = '0;
            errors        = 0;
            samples       = 0;
            codes         = 0;
        endfunction

        // 32767 * sin(pi/2 * j / quarter), odd Taylor series in Q30
        function int quarter_wave(int unsigned j);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned s;
            longint          sum;
            int              k;
            x    = (longint'(j) * 64'd1686629713) >> (msm_pkg::COS_TABLE_BITS_DEF - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (k = 1; k <= 6; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            s = longint'(sum);
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            return int'((s * 64'd32767 + (64'd1 << 29)) >> 30);
        endfunction

        function int cos_at(logic [31:0] ph);
            return cos_tab[ph >> IDX_SHIFT];
        endfunction

        function int keyed(int c);
            return (128 * 65534 + 255 * c) / 65534;
        endfunction

        function void set_reg(msm_pkg::cfg_reg_t idx, logic [31:0] val);
            case (idx)
                msm_pkg::REG_MODE:         mode = msm_pkg::mode_t'(val[1:0]);
                msm_pkg::REG_CARRIER_STEP: carrier_step = val;
                msm_pkg::REG_TONE_STEP:    tone_step = val;
                msm_pkg::REG_PHASE_DEPTH:  phase_depth = val[15:0];
                default:                   ;
            endcase
        endfunction

        function logic [7:0] predict_code(logic [9:0] x);
            int          b;
            int          centred;
            int          off;
            int          code;
            logic [31:0] ph;
            b       = (255 * int'(x)) / 1023;
            centred = 2 * b - 255;
            case (mode)
                msm_pkg::MODE_AM:
                    code = 128 + (centred * cos_at(carrier_phase)) / 65534;
                msm_pkg::MODE_PM:
                begin
                    off  = (centred * int'({16'd0, phase_depth})) / 255;
                    ph   = carrier_phase + (32'(off) << 16);
                    code = 128 + (255 * cos_at(ph)) / 65534;
                end
                msm_pkg::MODE_ASK:
                    code = (b > 128) ? keyed(cos_at(carrier_phase)) : 127;
                default:
                begin
                    ph   = tone_phase - 32'h4000_0000;
                    code = (b > 128) ? keyed(cos_at(carrier_phase)) : keyed(cos_at(ph));
                end
            endcase
            if (code < 0)
            begin
                code = 0;
            end
            if (code > 255)
            begin
                code = 255;
            end
            carrier_phase = carrier_phase + carrier_step;
            tone_phase    = tone_phase + tone_step;
            return 8'(code);
        endfunction

        function void take_sample(logic [9:0] x);
            expected_codes.push_back(predict_code(x));
            samples++;
        endfunction

        function void check_code(logic [7:0] got);
            logic [7:0] want;
            codes++;
            if (expected_codes.size() == 0)
            begin
                $error("dac_code: no code expected, got %0d", got);
                errors++;
            end
            else
            begin
                want = expected_codes.pop_front();
                if (got !== want)
                begin
                    $error("dac_code: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [msm_pkg::IN_TDATA_W-1:0]      s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [msm_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                cfg_wen;
    logic [msm_pkg::CFG_ADDR_W-1:0]      cfg_addr;
    logic [msm_pkg::CFG_DATA_W-1:0]      cfg_wdata;

    dac_scoreboard sb = new();
    int            burst_left = 0;
    int            rx_tick = 0;
    int            rx_style = 0;

    msm_pkg::mode_t set_mode [1:7] = '{msm_pkg::MODE_AM, msm_pkg::MODE_PM,
                                       msm_pkg::MODE_ASK, msm_pkg::MODE_FSK,
                                       msm_pkg::MODE_PM, msm_pkg::MODE_AM,
                                       msm_pkg::MODE_FSK};
    logic [31:0] set_cstep [1:7] = '{32'd429496730, 32'd429496730, 32'hFFFF_FFFF, 32'd0,
                                     32'h0123_4567, 32'h8000_0000, 32'd1};
    logic [31:0] set_tstep [1:7] = '{32'd42949673, 32'd42949673, 32'd42949673,
                                     32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0400_0000};
    logic [15:0] set_depth [1:7] = '{16'd10430, 16'd65535, 16'd10430, 16'd0,
                                     16'd0, 16'd32768, 16'd1};
    logic [9:0]  edge_samples [6] = '{10'd0, 10'd1023, 10'd517, 10'd518,
                                      10'h155, 10'h2AA};

    multimode_sample_modulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_code(m_tdata[msm_pkg::CODE_W-1:0]);
            end
            rx_tick++;
            if (rx_tick % 64 == 0)
            begin
                rx_style = $urandom_range(0, 3);
            end
            case (rx_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_tick / 3) % 2 == 0);
            endcase
        end
    end

    function automatic logic [9:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return 10'd0;
        end
        if (r == 1)
        begin
            return 10'd1023;
        end
        if (r < 5)
        begin
            return 10'($urandom_range(505, 530));
        end
        return 10'($urandom);
    endfunction

    task automatic push_sample(input logic [9:0] x);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
            begin
                gap = $urandom_range(10, 30);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                      : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= msm_pkg::IN_TDATA_W'(x);
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_sample(x);
    endtask

    task automatic write_reg(input msm_pkg::cfg_reg_t idx, input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // upper bits of mode and depth writes carry junk, which must be dropped
    task automatic program_regs(input msm_pkg::mode_t md, input logic [31:0] cstep,
                                input logic [31:0] tstep, input logic [15:0] depth);
        write_reg(msm_pkg::REG_MODE, {30'($urandom), md});
        write_reg(msm_pkg::REG_CARRIER_STEP, cstep);
        write_reg(msm_pkg::REG_TONE_STEP, tstep);
        write_reg(msm_pkg::REG_PHASE_DEPTH, {16'($urandom), depth});
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(0, 32'h00FF_FFFF));
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    initial
    begin
        int p;
        int i;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = msm_pkg::REG_MODE;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= 1 && p <= 7)
            begin
                program_regs(set_mode[p], set_cstep[p], set_tstep[p], set_depth[p]);
            end
            else if (p > 7)
            begin
                program_regs(msm_pkg::mode_t'($urandom_range(0, 3)), pick_step(),
                             pick_step(), 16'($urandom));
            end
            if (p < 4)
            begin
                for (i = 0; i < 6; i++)
                begin
                    push_sample(edge_samples[i]);
                end
            end
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                push_sample(pick_sample());
            end
            s_tvalid   <= 1'b0;
            burst_left = 0;
            while (sb.pending() != 0)
            begin
                @(posedge clk);
            end
            @(posedge clk);
        end

        repeat (20) @(posedge clk);
        $display("%0d samples over %0d register settings (all modes, step and depth extremes)",
                 sb.samples, NUM_PHASES);
        $display("%0d DAC codes compared, %0d mismatches", sb.codes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("multimode_sample_modulator_unit_tb: clean");
        end
        else
        begin
            $display("multimode_sample_modulator_unit_tb: errors");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("multimode_sample_modulator_unit_tb: errors");
        $finish;
    end

endmodule
